>>> design/lir_pkg.sv
// Shared types and constants for the linear interpolation resampler.
package lir_pkg;

  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int FRAC_BITS_DEF    = 24;
  localparam int MAX_UPSAMPLE_DEF = 64;

  localparam int STEP_W      = 32;
  localparam int PH_W        = STEP_W + 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS     = 1'd1;

  localparam logic [STEP_W-1:0] PHASE_STEP_RESET = 32'd16777216;

  typedef enum logic [2:0] {
    CMD_BYPASS = 3'b001,
    CMD_FIRST  = 3'b010,
    CMD_INTERP = 3'b100
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic      eoi;
  } cmd_ctl_t;

endpackage

>>> design/lir_in_if.sv
// Input sample channel: valid/ready handshake with sample payload.
interface lir_in_if #(
  parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          end_of_input;

  modport source (output valid, output sample, output end_of_input, input ready);
  modport sink   (input valid, input sample, input end_of_input, output ready);
endinterface

>>> design/lir_out_if.sv
// Result sample channel: valid/ready handshake with resampled payload.
interface lir_out_if #(
  parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          last_of_run;

  modport source (output valid, output out_sample, output last_of_run, input ready);
  modport sink   (input valid, input out_sample, input last_of_run, output ready);
endinterface

>>> design/lir_front.sv
// Front end: accepts input beats, tracks the previous sample, classifies each item.
module lir_front #(
  parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  lir_in_if.sink                        in_chan,
  input  logic                          bypass,
  input  logic                          q_full,
  output logic                          push,
  output lir_pkg::cmd_ctl_t             push_ctl,
  output logic signed [SAMPLE_BITS-1:0] push_a,
  output logic signed [SAMPLE_BITS-1:0] push_b
);

  logic signed [SAMPLE_BITS-1:0] prev_r;
  logic                          have_r;

  assign in_chan.ready = !q_full;
  assign push          = in_chan.valid && !q_full;
  assign push_a        = prev_r;
  assign push_b        = in_chan.sample;

  always_comb begin
    push_ctl.eoi = in_chan.end_of_input;
    priority if (bypass) begin
      push_ctl.kind = lir_pkg::CMD_BYPASS;
    end else if (!have_r) begin
      push_ctl.kind = lir_pkg::CMD_FIRST;
    end else begin
      push_ctl.kind = lir_pkg::CMD_INTERP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (push) begin
      // bypass keeps the stream unless the beat ends it
      if (!bypass || in_chan.end_of_input) begin
        have_r <= !bypass && !in_chan.end_of_input;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (push && !bypass) begin
      prev_r <= in_chan.sample;
    end
  end

endmodule

>>> design/lir_queue.sv
// Short command queue between front end and back end.
module lir_queue #(
  parameter int SAMPLE_BITS = lir_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  lir_pkg::cmd_ctl_t             push_ctl,
  input  logic signed [SAMPLE_BITS-1:0] push_a,
  input  logic signed [SAMPLE_BITS-1:0] push_b,
  input  logic                          pop,
  output logic                          full,
  output logic                          head_valid,
  output lir_pkg::cmd_ctl_t             head_ctl,
  output logic signed [SAMPLE_BITS-1:0] head_a,
  output logic signed [SAMPLE_BITS-1:0] head_b
);

  localparam int DEPTH = lir_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lir_pkg::cmd_ctl_t             ctl_mem [DEPTH];
  logic signed [SAMPLE_BITS-1:0] a_mem   [DEPTH];
  logic signed [SAMPLE_BITS-1:0] b_mem   [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_ctl   = ctl_mem[rd_ptr_r];
  assign head_a     = a_mem[rd_ptr_r];
  assign head_b     = b_mem[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_mem[wr_ptr_r] <= push_ctl;
      a_mem[wr_ptr_r]   <= push_a;
      b_mem[wr_ptr_r]   <= push_b;
    end
  end

endmodule

>>> design/lir_back.sv
// Back end: phase sequencer, interpolation multiplier and output register.
module lir_back #(
  parameter int SAMPLE_BITS  = lir_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS    = lir_pkg::FRAC_BITS_DEF,
  parameter int MAX_UPSAMPLE = lir_pkg::MAX_UPSAMPLE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  input  lir_pkg::cmd_ctl_t             cmd_ctl,
  input  logic signed [SAMPLE_BITS-1:0] cmd_a,
  input  logic signed [SAMPLE_BITS-1:0] cmd_b,
  output logic                          cmd_pop,
  input  logic [lir_pkg::STEP_W-1:0]    step,
  input  logic [lir_pkg::STEP_W:0]      step_half,
  lir_out_if.source                     out_chan
);

  localparam int PH_W   = lir_pkg::PH_W;
  localparam int STEP_W = lir_pkg::STEP_W;
  localparam int N_W    = $clog2(MAX_UPSAMPLE + 1);
  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int SUM_W  = SAMPLE_BITS + FRAC_BITS + 2;
  localparam logic [PH_W-1:0]  ONE     = PH_W'(1) << FRAC_BITS;
  localparam logic [PH_W-1:0]  TWO_ONE = PH_W'(1) << (FRAC_BITS + 1);
  localparam logic [SUM_W-1:0] HALF    = SUM_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_START  = 4'b0010,
    S_INTERP = 4'b0100,
    S_HOLD   = 4'b1000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [PH_W-1:0]                ph_r, ph_nxt;
  logic [N_W-1:0]                 n_r, n_nxt;
  logic [STEP_W-1:0]              phase_acc_r, phase_acc_nxt;
  lir_pkg::cmd_ctl_t              ctl_r;
  logic signed [SAMPLE_BITS-1:0]  a_r, b_r;
  logic signed [DIFF_W-1:0]       diff_r;

  logic                           gen_emit, gen_last, gen_hold;
  logic [FRAC_BITS-1:0]           gen_frac;
  logic signed [SUM_W-1:0]        prod;

  logic                           p_valid_r, p_last_r;
  logic signed [SAMPLE_BITS-1:0]  p_a_r;
  logic signed [SUM_W-1:0]        p_prod_r;
  logic signed [SUM_W-1:0]        sum;

  logic                           out_valid_r, out_last_r;
  logic signed [SAMPLE_BITS-1:0]  out_sample_r;
  logic                           out_load, p_free;

  logic [STEP_W-1:0]              half;
  logic [PH_W-1:0]                ph1, ph1h, ph2, start_ph2;
  logic [N_W-1:0]                 n_inc;
  logic                           n_more, half_fits, start_hold_ok, interp_hold_ok;
  logic                           interp_more, interp_hold, hold_more;

  assign out_load = p_valid_r && (!out_valid_r || out_chan.ready);
  assign p_free   = !p_valid_r || out_load;

  assign half           = step >> 1;
  assign ph1            = ph_r + PH_W'(step);
  assign ph1h           = ph_r + PH_W'(step_half);
  assign ph2            = (ph1 >= ONE) ? ph1 - ONE : '0;
  assign start_ph2      = (ph_r >= ONE) ? ph_r - ONE : '0;
  assign n_inc          = n_r + N_W'(1);
  assign n_more         = n_inc < N_W'(MAX_UPSAMPLE);
  assign half_fits      = PH_W'(half) <= ONE;
  assign start_hold_ok  = (start_ph2 + PH_W'(half)) <= ONE;
  // ph2 + half <= 1 rewritten against ph + step + half to drop the subtract
  assign interp_hold_ok = (ph1 >= ONE) ? (ph1h <= TWO_ONE) : half_fits;
  assign interp_more    = (ph1 < ONE) && n_more;
  assign interp_hold    = ctl_r.eoi && n_more && interp_hold_ok;
  assign hold_more      = n_more && (ph1h <= ONE);

  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    n_nxt         = n_r;
    phase_acc_nxt = phase_acc_r;
    cmd_pop       = 1'b0;
    gen_emit      = 1'b0;
    gen_last      = 1'b0;
    gen_hold      = 1'b1;
    gen_frac      = '0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop   = 1'b1;
          ph_nxt    = (cmd_ctl.kind == lir_pkg::CMD_INTERP) ? PH_W'(phase_acc_r) : '0;
          n_nxt     = '0;
          state_nxt = S_START;
        end
      end
      S_START: begin
        priority if (ctl_r.kind == lir_pkg::CMD_BYPASS) begin
          if (p_free) begin
            gen_emit  = 1'b1;
            gen_last  = 1'b1;
            state_nxt = S_IDLE;
            if (ctl_r.eoi) begin
              phase_acc_nxt = '0;
            end
          end
        end else if (ctl_r.kind == lir_pkg::CMD_INTERP && ph_r < ONE) begin
          state_nxt = S_INTERP;
        end else if (ctl_r.eoi && start_hold_ok) begin
          ph_nxt    = start_ph2;
          state_nxt = S_HOLD;
        end else begin
          phase_acc_nxt = ctl_r.eoi ? '0 : start_ph2[STEP_W-1:0];
          state_nxt     = S_IDLE;
        end
      end
      S_INTERP: begin
        if (p_free) begin
          gen_emit = 1'b1;
          gen_hold = 1'b0;
          gen_frac = ph_r[FRAC_BITS-1:0];
          gen_last = !interp_more && !interp_hold;
          n_nxt    = n_inc;
          priority if (interp_more) begin
            ph_nxt = ph1;
          end else if (interp_hold) begin
            ph_nxt    = ph2;
            state_nxt = S_HOLD;
          end else begin
            phase_acc_nxt = ctl_r.eoi ? '0 : ph2[STEP_W-1:0];
            state_nxt     = S_IDLE;
          end
        end
      end
      S_HOLD: begin
        if (p_free) begin
          gen_emit = 1'b1;
          gen_last = !hold_more;
          n_nxt    = n_inc;
          ph_nxt   = ph1;
          if (!hold_more) begin
            phase_acc_nxt = '0;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= '0;
      n_r         <= '0;
      phase_acc_r <= '0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      n_r         <= n_nxt;
      phase_acc_r <= phase_acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      ctl_r  <= cmd_ctl;
      a_r    <= cmd_a;
      b_r    <= cmd_b;
      diff_r <= DIFF_W'(cmd_b) - DIFF_W'(cmd_a);
    end
  end

  // held and bypassed beats use frac zero on the current sample
  assign prod = SUM_W'(diff_r) * SUM_W'($signed({1'b0, gen_frac}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (gen_emit) begin
      p_valid_r <= 1'b1;
    end else if (out_load) begin
      p_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (gen_emit) begin
      p_a_r    <= gen_hold ? b_r : a_r;
      p_prod_r <= prod;
      p_last_r <= gen_last;
    end
  end

  assign sum = $signed({{2{p_a_r[SAMPLE_BITS-1]}}, p_a_r, {FRAC_BITS{1'b0}}})
             + p_prod_r + $signed(HALF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= sum[FRAC_BITS +: SAMPLE_BITS];
      out_last_r   <= p_last_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_sample  = out_sample_r;
  assign out_chan.last_of_run = out_last_r;

  a_hold_needs_eoi: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_HOLD |-> ctl_r.eoi)
    else $error("hold run without end of input");

  a_interp_frac: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INTERP |-> ph_r < ONE)
    else $error("interpolation phase out of range");

  a_result_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INTERP || state_r == S_HOLD) |-> n_r < N_W'(MAX_UPSAMPLE))
    else $error("result count past cap");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (gen_emit && gen_last) |=> state_r == S_IDLE)
    else $error("last beat did not end the item");

endmodule

>>> design/linear_interp_resampler.sv
// Top level of the linear interpolation resampler: config registers and parts.
//
// in_chan carries signed samples plus an end_of_input flag; out_chan carries
// resampled samples plus last_of_run on the final result of each input beat.
// Both use valid/ready; a beat moves when both are high. cfg_we writes
// register cfg_index (phase_step, bypass) from cfg_wdata; write only while idle.
// phase_step values below 1/MAX_UPSAMPLE are raised to that minimum when
// written.
// The front end accepts a beat whenever its two-entry command queue has room,
// so input is taken while results still wait at the output. The back end
// takes one command at a time: it dequeues in S_IDLE, sets up the phase in
// S_START, then gives one result per cycle while the product register is
// free, at most MAX_UPSAMPLE per item; a bypassed beat emits in S_START.
// The single interpolation multiplier and the phase accumulator set that
// pace. With the back end idle, a beat goes through the queue, S_START,
// S_INTERP or S_HOLD (neither when bypassed), product and output registers.
// A stream's first sample gives no result unless it also ends the stream.
// Reset (rst_n low, synchronous) empties the queue and output register and
// restores phase_step to 1.0, bypass off and a fresh stream. When the
// receiver holds ready low, the output register and one product stage fill,
// then the back end stalls, the queue fills and in_chan.ready drops.
module linear_interp_resampler #(
  parameter int SAMPLE_BITS  = lir_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS    = lir_pkg::FRAC_BITS_DEF,
  parameter int MAX_UPSAMPLE = lir_pkg::MAX_UPSAMPLE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lir_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lir_pkg::CFG_DATA_W-1:0] cfg_wdata,
  lir_in_if.sink                         in_chan,
  lir_out_if.source                      out_chan
);

  localparam int STEP_W = lir_pkg::STEP_W;
  localparam logic [STEP_W-1:0] MIN_STEP =
    STEP_W'(((64'd1 << FRAC_BITS) + 64'(MAX_UPSAMPLE) - 64'd1) / 64'(MAX_UPSAMPLE));
  localparam logic [STEP_W-1:0] STEP_RST =
    (lir_pkg::PHASE_STEP_RESET < MIN_STEP) ? MIN_STEP : lir_pkg::PHASE_STEP_RESET;
  localparam logic [STEP_W:0] STEP_HALF_RST =
    {1'b0, STEP_RST} + {2'b0, STEP_RST[STEP_W-1:1]};

  logic [STEP_W-1:0] step_r;
  logic [STEP_W:0]   step_half_r;
  logic              bypass_r;
  logic [STEP_W-1:0] step_clamped;

  logic                          push, q_full, q_valid, q_pop;
  lir_pkg::cmd_ctl_t             push_ctl, head_ctl;
  logic signed [SAMPLE_BITS-1:0] push_a, push_b, head_a, head_b;

  assign step_clamped = (cfg_wdata[STEP_W-1:0] < MIN_STEP) ? MIN_STEP
                                                           : cfg_wdata[STEP_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_RST;
      step_half_r <= STEP_HALF_RST;
      bypass_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lir_pkg::CFG_PHASE_STEP: begin
          step_r      <= step_clamped;
          step_half_r <= {1'b0, step_clamped} + {2'b0, step_clamped[STEP_W-1:1]};
        end
        lir_pkg::CFG_BYPASS: begin
          bypass_r <= cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  lir_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .bypass   (bypass_r),
    .q_full   (q_full),
    .push     (push),
    .push_ctl (push_ctl),
    .push_a   (push_a),
    .push_b   (push_b)
  );

  lir_queue #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ctl   (push_ctl),
    .push_a     (push_a),
    .push_b     (push_b),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_ctl   (head_ctl),
    .head_a     (head_a),
    .head_b     (head_b)
  );

  lir_back #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .FRAC_BITS    (FRAC_BITS),
    .MAX_UPSAMPLE (MAX_UPSAMPLE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ctl   (head_ctl),
    .cmd_a     (head_a),
    .cmd_b     (head_b),
    .cmd_pop   (q_pop),
    .step      (step_r),
    .step_half (step_half_r),
    .out_chan  (out_chan)
  );

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the linear interpolation resampler.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SMP_W   = lir_pkg::SAMPLE_BITS_DEF;
  localparam int FRAC_W  = lir_pkg::FRAC_BITS_DEF;
  localparam int MAX_RUN = lir_pkg::MAX_UPSAMPLE_DEF;
  localparam int STEP_W  = lir_pkg::STEP_W;
  localparam int IDX_W   = lir_pkg::CFG_IDX_W;
  localparam int DATA_W  = lir_pkg::CFG_DATA_W;

  localparam longint unsigned ONE_Q    = 64'd1 << FRAC_W;
  localparam longint unsigned MIN_STEP = (ONE_Q + MAX_RUN - 1) / MAX_RUN;
  localparam longint          HALF_RANGE = 64'sd1 <<< (SMP_W - 1);

  localparam int RANDOM_ITEMS = 92;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct {
    logic [SMP_W-1:0] smp;
    logic             last;
  } resampled_t;

  class resample_scoreboard;
    logic [STEP_W-1:0] phase_step;
    bit                bypass_on;
    logic [SMP_W-1:0]  prev_smp;
    bit                have_prev;
    longint unsigned   phase_acc;
    resampled_t        pending_resamples[$];
    int unsigned       mismatches;

    function new();
      phase_step = lir_pkg::PHASE_STEP_RESET;
      bypass_on  = 1'b0;
      mismatches = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      prev_smp  = '0;
      have_prev = 1'b0;
      phase_acc = 0;
    endfunction

    function void set_register(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      if (idx == lir_pkg::CFG_PHASE_STEP) begin
        phase_step = data;
      end else if (idx == lir_pkg::CFG_BYPASS) begin
        bypass_on = data[0];
      end
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: %s", msg);
      end
    endfunction

    // prev + frac*(cur - prev), offset to stay nonnegative, round half up
    function logic [SMP_W-1:0] blend(logic [SMP_W-1:0] a, logic [SMP_W-1:0] b,
                                     longint unsigned frac);
      longint sa;
      longint sb;
      longint acc;
      sa  = longint'($signed(a));
      sb  = longint'($signed(b));
      acc = (sa + HALF_RANGE) * longint'(ONE_Q) + (sb - sa) * longint'(frac)
          + longint'(ONE_Q >> 1);
      return SMP_W'((acc >>> FRAC_W) - HALF_RANGE);
    endfunction

    function void push(logic [SMP_W-1:0] smp);
      resampled_t r;
      r.smp  = smp;
      r.last = 1'b0;
      pending_resamples.push_back(r);
    endfunction

    function void take_sample(logic [SMP_W-1:0] smp, logic eoi);
      longint unsigned stp;
      longint unsigned ph;
      int              n;
      n = 0;
      if (bypass_on) begin
        push(smp);
        pending_resamples[pending_resamples.size()-1].last = 1'b1;
        if (eoi) clear_stream();
        return;
      end
      stp = phase_step;
      if (stp < MIN_STEP) stp = MIN_STEP;

      if (have_prev) begin
        ph = phase_acc;
        while (ph < ONE_Q && n < MAX_RUN) begin
          push(blend(prev_smp, smp, ph));
          n++;
          ph += stp;
        end
        ph = (ph >= ONE_Q) ? ph - ONE_Q : 0;
      end else begin
        ph        = 0;
        have_prev = 1'b1;
      end
      prev_smp = smp;

      if (eoi) begin
        // repeat the final sample to round the stream length
        while (n < MAX_RUN && ph + (stp >> 1) <= ONE_Q) begin
          push(smp);
          n++;
          ph += stp;
        end
        clear_stream();
      end else begin
        phase_acc = ph & 64'hFFFF_FFFF;
      end
      if (n > 0) pending_resamples[pending_resamples.size()-1].last = 1'b1;
    endfunction

    function void check_result(logic [SMP_W-1:0] smp, logic last);
      resampled_t want;
      if (pending_resamples.size() == 0) begin
        flag($sformatf("result %0d last %0b with nothing expected", $signed(smp), last));
        return;
      end
      want = pending_resamples.pop_front();
      if (want.smp !== smp) begin
        flag($sformatf("out_sample expected %0d got %0d",
                       $signed(want.smp), $signed(smp)));
      end
      if (want.last !== last) begin
        flag($sformatf("last_of_run expected %0b got %0b (sample %0d)",
                       want.last, last, $signed(want.smp)));
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [DATA_W-1:0] cfg_wdata;
  bit                steady;

  lir_in_if  in_chan();
  lir_out_if out_chan();

  resample_scoreboard sb;

  linear_interp_resampler i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result sink: check each beat, then pick ready for the next edge.
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        sb.check_result(out_chan.out_sample, out_chan.last_of_run);
      end
      out_chan.ready <= steady || ($urandom_range(99) >= 18);
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_register(idx, data);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [STEP_W-1:0] step, input logic byp);
    write_reg(lir_pkg::CFG_PHASE_STEP, step);
    write_reg(lir_pkg::CFG_BYPASS, {{(DATA_W-1){1'b0}}, byp});
  endtask

  task automatic drive_beat(input logic [SMP_W-1:0] smp, input logic eoi);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 18) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.sample       <= smp;
    in_chan.end_of_input <= eoi;
    do @(posedge clk); while (!in_chan.ready);
    sb.take_sample(smp, eoi);
  endtask

  // Drop valid, wait for every expected result, then let trailing work finish.
  task automatic settle(input int pad);
    in_chan.valid <= 1'b0;
    while (sb.pending_resamples.size() != 0) @(posedge clk);
    repeat (pad) @(posedge clk);
  endtask

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(9))
      0:       return lir_pkg::PHASE_STEP_RESET;
      1:       return STEP_W'($urandom_range(0, int'(MIN_STEP) - 1));
      2:       return STEP_W'($urandom_range(int'(MIN_STEP), 32'h0080_0000));
      3, 4:    return STEP_W'($urandom_range(32'h0080_0000, 32'h0200_0000));
      5:       return $urandom;
      6:       return 32'hFFFF_FFFF;
      default: return STEP_W'($urandom_range(32'h0040_0000, 32'h0140_0000));
    endcase
  endfunction

  function automatic logic [SMP_W-1:0] next_sample(input logic [SMP_W-1:0] prev);
    case ($urandom_range(3))
      0:       return SMP_W'($urandom);
      1:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return prev + SMP_W'($urandom_range(0, 2000)) - SMP_W'(1000);
    endcase
  endfunction

  initial begin
    int               sent;
    int               phase_no;
    int               streams;
    int               len;
    logic [SMP_W-1:0] walk;
    logic             eoi;

    sb       = new();
    sent     = 0;
    phase_no = 0;
    walk     = '0;
    steady   = 1'b0;

    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_index            <= lir_pkg::CFG_PHASE_STEP;
    cfg_wdata            <= '0;
    in_chan.valid        <= 1'b0;
    in_chan.sample       <= '0;
    in_chan.end_of_input <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // unity rate across the sample extremes, then a one-sample stream
    set_config(lir_pkg::PHASE_STEP_RESET, 1'b0);
    drive_beat(16'h7FFF, 1'b0);
    drive_beat(16'h8000, 1'b0);
    drive_beat(16'h7FFF, 1'b0);
    drive_beat(16'h0000, 1'b0);
    drive_beat(16'hFFFF, 1'b1);
    drive_beat(16'd12345, 1'b1);
    settle(20);

    // step below the floor runs at the cap of results per beat
    set_config('0, 1'b0);
    drive_beat(16'h8000, 1'b0);
    drive_beat(16'h7FFF, 1'b1);
    settle(20);

    // heavy decimation: most beats give nothing
    set_config(32'hFFFF_FFFF, 1'b0);
    drive_beat(16'd1000, 1'b0);
    drive_beat(16'd2000, 1'b0);
    drive_beat(16'd3000, 1'b0);
    drive_beat(16'd4000, 1'b1);
    settle(20);

    // leave a stream open across bypass, then close it through bypass
    set_config(32'h0180_0000, 1'b0);
    drive_beat(16'(-20000), 1'b0);
    drive_beat(16'(20000), 1'b0);
    drive_beat(16'hFFFF, 1'b1);
    drive_beat(16'd500, 1'b0);
    settle(20);
    set_config(lir_pkg::PHASE_STEP_RESET, 1'b1);
    drive_beat(16'h7FFF, 1'b0);
    drive_beat(16'h8000, 1'b0);
    settle(20);
    set_config(32'h0080_0000, 1'b0);
    drive_beat(16'(-500), 1'b0);
    settle(20);
    set_config(lir_pkg::PHASE_STEP_RESET, 1'b1);
    drive_beat(16'(-7), 1'b1);
    settle(20);
    set_config(STEP_W'(MIN_STEP), 1'b0);
    drive_beat(16'd9, 1'b1);
    drive_beat(16'h8000, 1'b0);
    drive_beat(16'h7FFF, 1'b1);
    settle(20);

    while (sent < RANDOM_ITEMS) begin
      steady = (phase_no == 3);
      set_config(pick_step(), $urandom_range(5) == 0);
      streams = steady ? 6 : $urandom_range(1, 3);
      repeat (streams) begin
        len = $urandom_range(1, 10);
        for (int k = 0; k < len; k++) begin
          walk = next_sample(walk);
          // mostly closed streams; a few stay open or end early
          if (k == len - 1) eoi = ($urandom_range(9) != 0);
          else eoi = ($urandom_range(29) == 0);
          drive_beat(walk, eoi);
          sent++;
        end
      end
      settle(20);
      phase_no++;
    end
    steady = 1'b0;

    settle(100);
    while (sb.pending_resamples.size() != 0) begin
      sb.flag($sformatf("out_sample %0d never arrived",
                        $signed(sb.pending_resamples[0].smp)));
      void'(sb.pending_resamples.pop_front());
    end
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
